FILE: rtl/cts_pkg.sv
// Shared types, widths and constants of the cosh series evaluator.
`timescale 1ns / 1ps
package cts_pkg;

  // Fixed field widths
  localparam int X_W      = 46;  // signed argument
  localparam int XSQ_W    = 50;  // unsigned square of the argument
  localparam int SUM_W    = 63;  // sum, term and threshold
  localparam int KOUT_W   = 6;   // reported term index
  localparam int CFG_IDX_W = 2;

  // Multiplier: 63 x 50 bits, eight multiplier bits per step, MSB first
  localparam int PROD_W    = SUM_W + XSQ_W;
  localparam int MUL_DIG   = 8;
  localparam int MUL_B_W   = 56;
  localparam int MUL_STEPS = MUL_B_W / MUL_DIG;

  // Parameter defaults
  localparam int MAX_TERMS_DEF = 63;
  localparam int FRAC_BITS_DEF = 40;

  // Register reset values
  localparam logic [SUM_W-1:0]  EPS_RST        = 63'd10995;
  localparam logic [KOUT_W-1:0] TERM_COUNT_RST = 6'd8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_MODE  = 2'd0,
    CFG_EPS        = 2'd1,
    CFG_TERM_COUNT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              stop_mode;
    logic [SUM_W-1:0]  eps;
    logic [KOUT_W-1:0] term_count;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_x;
    logic mul_step;
    logic sq_end;
    logic iter_init;
    logic div_load;
    logic div_step;
    logic acc;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic more;
  } ctrl_stat_t;

  // Number of 8-bit dividend digits after the fraction shift
  function automatic int div_digits(int frac);
    return (PROD_W - frac + MUL_DIG - 1) / MUL_DIG;
  endfunction

endpackage

FILE: rtl/cts_cfg_regs.sv
// Configuration register file of the cosh series evaluator.
`timescale 1ns / 1ps
module cts_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cts_pkg::SUM_W-1:0]     cfg_data_i,
  output cts_pkg::cfg_t                 cfg_o
);
  import cts_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Write one register per beat; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_mode  <= 1'b0;
      cfg_q.eps        <= EPS_RST;
      cfg_q.term_count <= TERM_COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STOP_MODE:  cfg_q.stop_mode  <= cfg_data_i[0];
        CFG_EPS:        cfg_q.eps        <= cfg_data_i;
        CFG_TERM_COUNT: cfg_q.term_count <= cfg_data_i[KOUT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/cts_datapath.sv
// Datapath: square, shared digit multiplier, digit divider, sum and flags.
`timescale 1ns / 1ps
module cts_datapath #(
  parameter int MAX_TERMS = cts_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = cts_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cts_pkg::cfg_t              cfg_i,
  input  cts_pkg::ctrl_cmd_t         cmd_i,
  output cts_pkg::ctrl_stat_t        stat_o,
  input  logic [cts_pkg::X_W-1:0]    arg_x_i,
  output logic [cts_pkg::SUM_W-1:0]  series_sum_o,
  output logic [cts_pkg::SUM_W-1:0]  last_term_o,
  output logic [cts_pkg::KOUT_W-1:0] terms_used_o,
  output logic                       limit_hit_o
);
  import cts_pkg::*;

  localparam int KW     = $clog2(MAX_TERMS + 1);
  localparam int DW     = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS - 1) + 1);
  localparam int DIGITS = div_digits(FRAC_BITS);
  localparam int DVD_W  = DIGITS * MUL_DIG;
  localparam int DPW    = 2 * KW + 4;

  localparam logic [SUM_W-1:0] ONE      = SUM_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [XSQ_W-1:0] XSQ_MAX  = {XSQ_W{1'b1}};
  localparam logic [KW-1:0]    KMAX     = KW'(MAX_TERMS);

  logic [SUM_W-1:0]   a_q;
  logic [MUL_B_W-1:0] b_q;
  logic [PROD_W-1:0]  p_q;
  logic [XSQ_W-1:0]   xsq_q;
  logic [SUM_W-1:0]   term_q;
  logic [SUM_W-1:0]   sum_q;
  logic [KW-1:0]      k_q;
  logic [DW-1:0]      d_q;
  logic [DVD_W-1:0]   dvd_q;
  logic [DW-1:0]      rem_q;
  logic [DVD_W-1:0]   quo_q;
  logic               flag_q;

  logic [X_W-1:0]               mag;
  logic [SUM_W+MUL_DIG-1:0]     mul_dig;
  logic [PROD_W-1:0]            p_shift;
  logic [KW:0]                  k_next;
  logic [KW+1:0]                two_k;
  logic [DPW-1:0]               d_full;
  logic [DW:0]                  div_r;
  logic [MUL_DIG-1:0]           q_dig;
  logic [SUM_W-1:0]             term_new;
  logic                         term_sat;
  logic [SUM_W:0]               sum_new;
  logic [KW-1:0]                limit;
  logic                         clamp;
  logic                         term_ge_eps;

  // Magnitude of the signed argument; the most negative value maps to 2^45
  assign mag = arg_x_i[X_W-1] ? (~arg_x_i + 1'b1) : arg_x_i;

  // One 63 x 8 partial product per step
  assign mul_dig = (SUM_W+MUL_DIG)'(a_q) * (SUM_W+MUL_DIG)'(b_q[MUL_B_W-1 -: MUL_DIG]);
  assign p_shift = p_q >> FRAC_BITS;

  // Divisor 2k(2k-1) for the next term index
  assign k_next = {1'b0, k_q} + 1'b1;
  assign two_k  = {k_next, 1'b0};
  assign d_full = DPW'(two_k) * DPW'(two_k - 1'b1);

  // Eight restoring steps per dividend digit
  always_comb begin
    div_r = {1'b0, rem_q};
    q_dig = '0;
    for (int i = 0; i < MUL_DIG; i++) begin
      div_r = {div_r[DW-1:0], dvd_q[DVD_W-1-i]};
      if (div_r >= {1'b0, d_q}) begin
        div_r = div_r - {1'b0, d_q};
        q_dig[MUL_DIG-1-i] = 1'b1;
      end
    end
  end

  // Saturate the quotient into a term and add it to the sum
  assign term_sat = |quo_q[DVD_W-1:SUM_W];
  assign term_new = term_sat ? SUM_MAX : quo_q[SUM_W-1:0];
  assign sum_new  = {1'b0, sum_q} + {1'b0, term_new};

  // Term limit of the current mode
  assign clamp       = cfg_i.stop_mode && (int'(cfg_i.term_count) > MAX_TERMS);
  assign limit       = (cfg_i.stop_mode && !clamp) ? KW'(cfg_i.term_count) : KMAX;
  assign term_ge_eps = term_q >= cfg_i.eps;
  assign stat_o.more = (k_q < limit) && (cfg_i.stop_mode || term_ge_eps);

  // Control state of the evaluation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      flag_q <= 1'b0;
    end else begin
      if (cmd_i.sq_end) begin
        k_q    <= '0;
        flag_q <= clamp;
      end
      if (cmd_i.iter_init) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.acc && (term_sat || sum_new[SUM_W])) begin
        flag_q <= 1'b1;
      end
      if (cmd_i.finish && !cfg_i.stop_mode && term_ge_eps) begin
        flag_q <= 1'b1;
      end
    end
  end

  // Arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      a_q <= SUM_W'(mag);
      b_q <= MUL_B_W'(mag);
      p_q <= '0;
    end
    if (cmd_i.mul_step) begin
      p_q <= {p_q[PROD_W-MUL_DIG-1:0], {MUL_DIG{1'b0}}} + PROD_W'(mul_dig);
      b_q <= b_q << MUL_DIG;
    end
    if (cmd_i.sq_end) begin
      xsq_q  <= (|p_shift[PROD_W-1:XSQ_W]) ? XSQ_MAX : p_shift[XSQ_W-1:0];
      sum_q  <= ONE;
      term_q <= ONE;
    end
    if (cmd_i.iter_init) begin
      a_q <= term_q;
      b_q <= MUL_B_W'(xsq_q);
      p_q <= '0;
      d_q <= DW'(d_full);
    end
    if (cmd_i.div_load) begin
      dvd_q <= DVD_W'(p_shift);
      rem_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_q <= dvd_q << MUL_DIG;
      rem_q <= div_r[DW-1:0];
      quo_q <= {quo_q[DVD_W-MUL_DIG-1:0], q_dig};
    end
    if (cmd_i.acc) begin
      term_q <= term_new;
      sum_q  <= sum_new[SUM_W] ? SUM_MAX : sum_new[SUM_W-1:0];
    end
  end

  assign series_sum_o = sum_q;
  assign last_term_o  = term_q;
  assign terms_used_o = KOUT_W'(k_q);
  assign limit_hit_o  = flag_q;

endmodule

FILE: rtl/cts_ctrl.sv
// Controller: sequences square, multiply, divide and accumulate steps.
`timescale 1ns / 1ps
module cts_ctrl #(
  parameter int FRAC_BITS = cts_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                done_o,
  output cts_pkg::ctrl_cmd_t  cmd_o,
  input  cts_pkg::ctrl_stat_t stat_i
);
  import cts_pkg::*;

  localparam int DIGITS = div_digits(FRAC_BITS);
  localparam int CNT_N  = (DIGITS > MUL_STEPS) ? DIGITS : MUL_STEPS;
  localparam int CNT_W  = $clog2(CNT_N);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIGITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_END,
    ST_CHECK,
    ST_IT_MUL,
    ST_DIV_LD,
    ST_DIV,
    ST_ACC
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic              accept;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;
  assign done_o = done_q;

  // Decode commands from the current state
  always_comb begin
    cmd_o           = '0;
    cmd_o.load_x    = (state_q == ST_IDLE) && accept;
    cmd_o.mul_step  = (state_q == ST_SQ_MUL) || (state_q == ST_IT_MUL);
    cmd_o.sq_end    = (state_q == ST_SQ_END);
    cmd_o.iter_init = (state_q == ST_CHECK) && stat_i.more;
    cmd_o.finish    = (state_q == ST_CHECK) && !stat_i.more;
    cmd_o.div_load  = (state_q == ST_DIV_LD);
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.acc       = (state_q == ST_ACC);
  end

  // Advance state, step counter and handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            busy_q  <= 1'b1;
            cnt_q   <= '0;
            state_q <= ST_SQ_MUL;
          end
        end
        ST_SQ_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == MUL_LAST) begin
            state_q <= ST_SQ_END;
          end
        end
        ST_SQ_END: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          cnt_q <= '0;
          if (stat_i.more) begin
            state_q <= ST_IT_MUL;
          end else begin
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_IT_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == MUL_LAST) begin
            state_q <= ST_DIV_LD;
          end
        end
        ST_DIV_LD: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_LAST) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          state_q <= ST_CHECK;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/cosh_taylor_series.sv
// Top level of the Maclaurin-series cosh evaluator.
//
// Usage: raise start_i with arg_x_i (signed Q5.40) while busy_o is low; the
// argument is taken at that clock edge and busy_o rises. The result beat
// (series_sum_o, last_term_o, terms_used_o, limit_hit_o) is shown for exactly
// one cycle with done_o high; the receiver cannot stall it, so capture it then.
// busy_o is already low in the done_o cycle, so the next argument may be
// started there. Registers (stop mode, eps threshold, fixed term count) are
// written through cfg_valid_i/cfg_ready_o, cfg_ready_o is always high, and a
// write is meant only while the block is idle.
// Each term added takes a multiply on the shared 63 x 8 bit multiplier (7
// steps per product) and a divide by 2k(2k-1) on the one-digit-per-cycle
// divider, which works on D = ceil((113 - FRAC_BITS) / 8) digits (10 at 40
// fraction bits); one argument is worked on at a time.
// Reset: asynchronous and active low; the registers return to their reset
// values and the block comes up idle.
`timescale 1ns / 1ps
module cosh_taylor_series #(
  parameter int MAX_TERMS = cts_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = cts_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [cts_pkg::X_W-1:0]       arg_x_i,
  output logic                          done_o,
  output logic [cts_pkg::SUM_W-1:0]     series_sum_o,
  output logic [cts_pkg::SUM_W-1:0]     last_term_o,
  output logic [cts_pkg::KOUT_W-1:0]    terms_used_o,
  output logic                          limit_hit_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cts_pkg::SUM_W-1:0]     cfg_data_i
);
  import cts_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Configuration registers
  cts_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Step sequencer
  cts_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  // Arithmetic
  cts_datapath #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .arg_x_i      (arg_x_i),
    .series_sum_o (series_sum_o),
    .last_term_o  (last_term_o),
    .terms_used_o (terms_used_o),
    .limit_hit_o  (limit_hit_o)
  );

endmodule
